>>> rtl/core/stanley_steering_rate_limited_core_macros.svh
// Assertion macros for the Stanley steering core.
// Included by the top level; no other dependencies.
`ifndef STANLEY_STEERING_RATE_LIMITED_CORE_MACROS_SVH
`define STANLEY_STEERING_RATE_LIMITED_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SSRL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SSRL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSRL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define SSRL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> rtl/core/ssrl_pkg.sv
// Shared types, constants and the arctangent table for the Stanley steering core.
// No dependencies.
`default_nettype none

package ssrl_pkg;

  typedef struct packed {
    logic signed [15:0] vehicle_heading;
    logic signed [15:0] path_heading;
    logic signed [15:0] lateral_error;
    logic signed [15:0] speed;
    logic               waypoint_valid;
    logic               frenet_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] steer_angle;
    logic [1:0]         status;
  } out_item_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_SOFTENING  = 2'd0;
  localparam logic [1:0] REG_MIN_SPEED  = 2'd1;
  localparam logic [1:0] REG_RATE_LIMIT = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK             = 2'd0;
  localparam logic [1:0] STATUS_WP_INVALID     = 2'd1;
  localparam logic [1:0] STATUS_FRENET_MISSING = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] SOFTENING_RST  = 16'd307;
  localparam logic [15:0] MIN_SPEED_RST  = 16'd26;
  localparam logic [14:0] RATE_LIMIT_RST = 15'd492;

  // Angles in Q3.13 radians.
  localparam logic signed [16:0] PI_Q      = 17'sd25736;
  localparam logic signed [16:0] TWO_PI_Q  = 17'sd51472;
  localparam logic signed [15:0] HALF_PI_Q = 16'sd12868;

  // CORDIC datapath width: the denominator scaled by 256 plus gain growth.
  localparam int CORDIC_W   = 28;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = 5;

  // atan(2^-i) rounded to Q3.13.
  function automatic logic signed [15:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    case (idx)
      5'd0:    return 16'sd6434;
      5'd1:    return 16'sd3798;
      5'd2:    return 16'sd2007;
      5'd3:    return 16'sd1019;
      5'd4:    return 16'sd511;
      5'd5:    return 16'sd256;
      5'd6:    return 16'sd128;
      5'd7:    return 16'sd64;
      5'd8:    return 16'sd32;
      5'd9:    return 16'sd16;
      5'd10:   return 16'sd8;
      5'd11:   return 16'sd4;
      5'd12:   return 16'sd2;
      5'd13:   return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ssrl_cordic.sv
// Iterative vectoring CORDIC that returns atan2(y, x) in Q3.13, one micro-rotation a cycle.
// Depends on ssrl_pkg.
`default_nettype none

module ssrl_cordic import ssrl_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [16:0]        x_in,
  input  wire logic signed [15:0] y_in,
  output logic                    done,
  output logic signed [15:0]      z_out
);

  localparam int N = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
  localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(N - 1);

  logic                         run_r, run_nxt;
  logic                         done_r, done_nxt;
  logic [ATAN_IDX_W-1:0]        step_r, step_nxt;
  logic signed [CORDIC_W-1:0]   x_r, x_nxt;
  logic signed [CORDIC_W-1:0]   y_r, y_nxt;
  logic signed [15:0]           z_r, z_nxt;
  logic signed [CORDIC_W-1:0]   dx, dy;

  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (start) begin
      // Zero numerator and zero denominator are answered without iterating.
      if (y_in == '0) begin
        z_nxt    = '0;
        done_nxt = 1'b1;
      end else if (x_in == '0) begin
        z_nxt    = y_in[15] ? -HALF_PI_Q : HALF_PI_Q;
        done_nxt = 1'b1;
      end else begin
        x_nxt    = signed'({3'b000, x_in, 8'h00});
        y_nxt    = signed'({{(CORDIC_W-24){y_in[15]}}, y_in, 8'h00});
        z_nxt    = '0;
        step_nxt = '0;
        run_nxt  = 1'b1;
      end
    end else if (run_r) begin
      if (!y_r[CORDIC_W-1]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + atan_lut(step_r);
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - atan_lut(step_r);
      end
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign done  = done_r;
  assign z_out = z_r;

endmodule

`default_nettype wire

>>> rtl/core/stanley_steering_rate_limited_core.sv
// Stanley lateral steering controller with a rate-limited output angle.
// Channels: in_* carries one control tick per item, out_* one steering result per item.
// Both use valid/stall; an item moves on a clock edge with valid high and stall low.
// cfg_we writes softening gain (index 0), minimum speed (1) or rate limit (2).
// A valid tick waits in S_CORDIC, then passes S_LIMIT and S_DONE before its result is out_valid;
// the iterative CORDIC does one micro-rotation per cycle, capped at 24.
// A tick with zero lateral error or a zero denominator skips the iterations.
// A tick with an invalid waypoint or missing Frenet data skips the CORDIC and answers with angle 0.
// A new tick is not taken while one is in flight: in_stall is high from acceptance until the
// result moves to the output register.
// The output register holds a result while out_stall is high; the next tick is still taken
// and waits at its final stage until the register frees.
// Reset (rst_n low, synchronous) restores the default configuration, clears the stored angle
// and empties the block.
`default_nettype none
`include "stanley_steering_rate_limited_core_macros.svh"

module stanley_steering_rate_limited_core import ssrl_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CORDIC = 3'd1;
  localparam logic [2:0] S_LIMIT  = 3'd2;
  localparam logic [2:0] S_DONE   = 3'd3;

  logic [2:0]         state_r, state_nxt;
  logic [15:0]        softening_r;
  logic [15:0]        min_speed_r;
  logic [14:0]        rate_limit_r;
  logic signed [16:0] prev_r, prev_nxt;
  logic signed [15:0] head_err_r, head_err_nxt;
  logic signed [16:0] angle_r, angle_nxt;
  logic signed [16:0] res_angle_r, res_angle_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               in_acc;
  logic               out_load;
  logic signed [16:0] d_raw;
  logic signed [15:0] d_wrap;
  logic signed [16:0] spd_ext, min_ext;
  logic [15:0]        vel;
  logic [16:0]        den;
  logic               cor_start;
  logic               cor_done;
  logic signed [15:0] cor_z;
  logic signed [17:0] diff, rl_ext, lim_wide, lim_step;
  logic signed [16:0] lim_angle;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Heading error, wrapped once by a full turn into (-pi, pi].
  always_comb begin
    d_raw = 17'(in_data.vehicle_heading) - 17'(in_data.path_heading);
    if (d_raw > PI_Q) begin
      d_wrap = 16'(d_raw - TWO_PI_Q);
    end else if (d_raw <= -PI_Q) begin
      d_wrap = 16'(d_raw + TWO_PI_Q);
    end else begin
      d_wrap = 16'(d_raw);
    end
  end

  // Denominator: softening gain plus the speed clamped from below.
  assign spd_ext = 17'(in_data.speed);
  assign min_ext = signed'({1'b0, min_speed_r});
  assign vel     = (spd_ext > min_ext) ? in_data.speed : min_speed_r;
  assign den     = 17'(softening_r) + 17'(vel);

  assign cor_start = in_acc && in_data.waypoint_valid && in_data.frenet_valid;

  ssrl_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x_in  (den),
    .y_in  (in_data.lateral_error),
    .done  (cor_done),
    .z_out (cor_z)
  );

  // Rate limiter against the stored angle.
  always_comb begin
    rl_ext = signed'({3'b000, rate_limit_r});
    diff   = 18'(angle_r) - 18'(prev_r);
    if (diff > rl_ext) begin
      lim_wide = 18'(prev_r) + rl_ext;
    end else if (diff < -rl_ext) begin
      lim_wide = 18'(prev_r) - rl_ext;
    end else begin
      lim_wide = 18'(angle_r);
    end
    lim_angle = 17'(lim_wide);
    lim_step  = lim_wide - 18'(prev_r);
  end

  always_comb begin
    state_nxt      = state_r;
    prev_nxt       = prev_r;
    head_err_nxt   = head_err_r;
    angle_nxt      = angle_r;
    res_angle_nxt  = res_angle_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_data.waypoint_valid) begin
            res_angle_nxt  = '0;
            res_status_nxt = STATUS_WP_INVALID;
            state_nxt      = S_DONE;
          end else if (!in_data.frenet_valid) begin
            res_angle_nxt  = '0;
            res_status_nxt = STATUS_FRENET_MISSING;
            state_nxt      = S_DONE;
          end else begin
            head_err_nxt = d_wrap;
            state_nxt    = S_CORDIC;
          end
        end
      end
      S_CORDIC: begin
        if (cor_done) begin
          angle_nxt = 17'(head_err_r) + 17'(cor_z);
          state_nxt = S_LIMIT;
        end
      end
      S_LIMIT: begin
        prev_nxt       = lim_angle;
        res_angle_nxt  = lim_angle;
        res_status_nxt = STATUS_OK;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_data_nxt.steer_angle = res_angle_r;
          out_data_nxt.status      = res_status_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      prev_r       <= '0;
      softening_r  <= SOFTENING_RST;
      min_speed_r  <= MIN_SPEED_RST;
      rate_limit_r <= RATE_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SOFTENING:  softening_r  <= cfg_wdata;
          REG_MIN_SPEED:  min_speed_r  <= cfg_wdata;
          REG_RATE_LIMIT: rate_limit_r <= cfg_wdata[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    head_err_r   <= head_err_nxt;
    angle_r      <= angle_nxt;
    res_angle_r  <= res_angle_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SSRL_ASSERT_IMPLY(a_cordic_done_in_wait, clk, rst_n, cor_done, state_r == S_CORDIC, "CORDIC finished outside its wait state")
  `SSRL_ASSERT_IMPLY(a_error_angle_zero, clk, rst_n, out_valid_r && (out_data_r.status != STATUS_OK), out_data_r.steer_angle == '0, "error item carries a nonzero angle")
  `SSRL_ASSERT_IMPLY(a_step_within_limit, clk, rst_n, state_r == S_LIMIT, (lim_step <= rl_ext) && (lim_step >= -rl_ext), "angle step exceeds the rate limit")
  `SSRL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall, "block took an item but is not busy")

endmodule

`default_nettype wire
